[rtl/pvr_pkg.sv]
// Package of the PI voltage regulator: widths, reset values, register indexes,
// shared types and the saturation helper. Depends on nothing.
package pvr_pkg;

  localparam int unsigned SampPerUpdDef = 64;
  localparam int unsigned AdcBitsDef    = 10;
  localparam int unsigned SumW          = 17;
  localparam int unsigned AddrW         = 4;
  localparam int unsigned DataW         = 32;
  localparam int unsigned VoltW         = 31;
  localparam int unsigned GainW         = 24;
  localparam int unsigned DutyW         = 8;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned PrdW          = 56;
  localparam int unsigned AccW          = 42;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [DataW-1:0]        VoltScaleRst = 32'd656006;
  localparam logic [VoltW-1:0]        RefVoltRst   = 31'd786432;
  localparam logic signed [GainW-1:0] PropGainRst  = 24'sd65536;
  localparam logic signed [GainW-1:0] IntegGainRst = 24'sd6554;
  localparam logic signed [DataW-1:0] IntegRst     = 32'sd16711680;

  localparam logic signed [AccW-1:0] CtrlHigh = 42'sd16646144;
  localparam logic signed [AccW-1:0] CtrlMax  = 42'sd16711680;
  localparam logic signed [AccW-1:0] CtrlOne  = 42'sd65536;
  localparam logic [DutyW-1:0]       DutyOff  = 8'd255;

  typedef enum logic [1:0] {
    REG_VOLT_SCALE  = 2'd0,
    REG_REF_VOLTAGE = 2'd1,
    REG_PROP_GAIN   = 2'd2,
    REG_INTEG_GAIN  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERR,
    BK_KI,
    BK_INT,
    BK_KP,
    BK_CTRL
  } bk_state_e;

  typedef struct packed {
    logic [DataW-1:0] volt_scale;
    logic [VoltW-1:0] ref_voltage;
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
  } cfg_t;

  typedef struct packed {
    logic            upd;
    logic [SumW-1:0] sum;
  } job_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [DataW-1:0] r;
    if ((v[AccW-1:DataW-1] == '0) || (v[AccW-1:DataW-1] == '1)) begin
      r = v[DataW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/pvr_if.sv]
// Channel interfaces of the PI voltage regulator: the ADC sample channel and
// the result channel. Depends on pvr_pkg.
interface pvr_in_if #(
  parameter int unsigned ADC_BITS = pvr_pkg::AdcBitsDef
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;
  logic                enable;

  modport source (output valid, output sample, output enable, input ready);
  modport sink   (input valid, input sample, input enable, output ready);
endinterface

interface pvr_out_if;
  logic                        valid;
  logic                        ready;
  logic [pvr_pkg::DutyW-1:0]   duty;
  logic [pvr_pkg::VoltW-1:0]   voltage;

  modport source (output valid, output duty, output voltage, input ready);
  modport sink   (input valid, input duty, input voltage, output ready);
endinterface

[rtl/pvr_cfg.sv]
// APB register file of the PI voltage regulator: scale, reference and gains.
// Depends on pvr_pkg.
module pvr_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pvr_pkg::AddrW-1:0] paddr,
  input  logic [pvr_pkg::DataW-1:0] pwdata,
  output logic [pvr_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output pvr_pkg::cfg_t             cfg_o
);
  import pvr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_scale  <= VoltScaleRst;
      cfg_q.ref_voltage <= RefVoltRst;
      cfg_q.prop_gain   <= PropGainRst;
      cfg_q.integ_gain  <= IntegGainRst;
    end else if (wr) begin
      unique case (idx)
        REG_VOLT_SCALE:  cfg_q.volt_scale  <= pwdata;
        REG_REF_VOLTAGE: cfg_q.ref_voltage <= pwdata[VoltW-1:0];
        REG_PROP_GAIN:   cfg_q.prop_gain   <= pwdata[GainW-1:0];
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= pwdata[GainW-1:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOLT_SCALE:  prdata = cfg_q.volt_scale;
      REG_REF_VOLTAGE: prdata = DataW'(cfg_q.ref_voltage);
      REG_PROP_GAIN:   prdata = DataW'($signed(cfg_q.prop_gain));
      REG_INTEG_GAIN:  prdata = DataW'($signed(cfg_q.integ_gain));
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/pvr_front.sv]
// Front end of the PI voltage regulator: accepts samples, sums a block and
// hands update or disable jobs to the queue. Depends on pvr_pkg and pvr_if.
module pvr_front #(
  parameter int unsigned SAMPLES_PER_UPDATE = pvr_pkg::SampPerUpdDef,
  parameter int unsigned ADC_BITS           = pvr_pkg::AdcBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pvr_in_if.sink        smp_i,
  input  logic          full_i,
  output logic          push_o,
  output pvr_pkg::job_t job_o
);
  import pvr_pkg::*;

  localparam int unsigned CntW = $clog2(SAMPLES_PER_UPDATE + 1);

  logic [SumW-1:0] sum_q, sum_d, sum_nxt;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_nxt;
  logic            beat, done;

  assign smp_i.ready = !full_i;
  assign beat        = smp_i.valid && smp_i.ready;
  assign sum_nxt     = sum_q + SumW'(smp_i.sample[ADC_BITS-1:0]);
  assign cnt_nxt     = cnt_q + 1'b1;
  assign done        = (cnt_nxt == CntW'(SAMPLES_PER_UPDATE));

  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    push_o    = 1'b0;
    job_o.upd = smp_i.enable;
    job_o.sum = sum_nxt;
    if (beat) begin
      if (!smp_i.enable) begin
        push_o = 1'b1;
        sum_d  = '0;
        cnt_d  = '0;
      end else if (done) begin
        push_o = 1'b1;
        sum_d  = '0;
        cnt_d  = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/pvr_fifo.sv]
// Short job queue between the front end and the control sequencer of the
// PI voltage regulator. Depends on pvr_pkg.
module pvr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pvr_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output pvr_pkg::job_t data_o,
  input  logic          pop_i
);
  import pvr_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/pvr_back.sv]
// Control sequencer of the PI voltage regulator: one shared multiplier runs
// the voltage, integral and proportional steps. Depends on pvr_pkg and pvr_if.
module pvr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pvr_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  pvr_pkg::job_t job_i,
  output logic          job_pop_o,
  pvr_out_if.source     res_o
);
  import pvr_pkg::*;

  typedef enum logic [1:0] {
    MUL_VOLT,
    MUL_KI,
    MUL_KP
  } mul_sel_e;

  typedef struct packed {
    logic     pop;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_en;
    logic     int_en;
    logic     out_upd;
    logic     out_off;
  } bk_ctl_t;

  bk_state_e state_q, state_d;
  bk_ctl_t   ctl;

  logic signed [PrdW-1:0]       prod_q;
  logic        [VoltW-1:0]      volt_q;
  logic signed [DataW-1:0]      err_q;
  logic signed [DataW-1:0]      integ_q;
  logic        [DutyW-1:0]      duty_q;
  logic        [VoltW-1:0]      vout_q;
  logic                         out_valid_q;

  logic signed [DataW-1:0]      mul_a;
  logic signed [DataW:0]        mul_b;
  logic signed [2*DataW:0]      mul_full;
  logic        [DataW:0]        vshift;
  logic        [VoltW-1:0]      volt_sat;
  logic signed [DataW-1:0]      err_c;
  logic signed [PrdW-FracBits-1:0] prod_sh;
  logic signed [AccW-1:0]       acc_sum;
  logic signed [AccW-1:0]       u_c;
  logic signed [AccW-1:0]       int_new;
  logic                         out_free;

  assign out_free      = !out_valid_q || res_o.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.duty    = duty_q;
  assign res_o.voltage = vout_q;
  assign job_pop_o     = ctl.pop;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i && job_i.upd) begin
          state_d = BK_ERR;
        end
      end
      BK_ERR:  state_d = BK_KI;
      BK_KI:   state_d = BK_INT;
      BK_INT:  state_d = BK_KP;
      BK_KP:   state_d = BK_CTRL;
      BK_CTRL: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MUL_VOLT;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i && job_i.upd) begin
          ctl.pop    = 1'b1;
          ctl.mul_en = 1'b1;
        end else if (job_valid_i && out_free) begin
          ctl.pop     = 1'b1;
          ctl.out_off = 1'b1;
        end
      end
      BK_ERR: ctl.err_en = 1'b1;
      BK_KI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_KI;
      end
      BK_INT: ctl.int_en = 1'b1;
      BK_KP: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_KP;
      end
      BK_CTRL: ctl.out_upd = out_free;
      default: ctl = '0;
    endcase
  end

  always_comb begin
    case (ctl.mul_sel)
      MUL_KI: begin
        mul_a = err_q;
        mul_b = (DataW + 1)'($signed(cfg_i.integ_gain));
      end
      MUL_KP: begin
        mul_a = err_q;
        mul_b = (DataW + 1)'($signed(cfg_i.prop_gain));
      end
      default: begin
        mul_a = $signed(DataW'(job_i.sum));
        mul_b = $signed({1'b0, cfg_i.volt_scale});
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign vshift   = prod_q[SumW+DataW-1:FracBits];
  assign volt_sat = (|vshift[DataW:VoltW]) ? '1 : vshift[VoltW-1:0];
  assign err_c    = $signed({1'b0, volt_sat}) - $signed({1'b0, cfg_i.ref_voltage});
  assign prod_sh  = prod_q[PrdW-1:FracBits];
  assign acc_sum  = AccW'(prod_sh) + AccW'(integ_q);

  always_comb begin
    if (acc_sum > CtrlHigh) begin
      u_c = CtrlMax;
    end else if (acc_sum < CtrlOne) begin
      u_c = '0;
    end else begin
      u_c = acc_sum;
    end
  end

  assign int_new = u_c - AccW'(prod_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= IntegRst;
    end else begin
      state_q <= state_d;
      if (ctl.out_upd || ctl.out_off) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctl.int_en) begin
        integ_q <= sat32(acc_sum);
      end else if (ctl.out_upd) begin
        integ_q <= sat32(int_new);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mul_en) begin
      prod_q <= mul_full[PrdW-1:0];
    end
    if (ctl.err_en) begin
      volt_q <= volt_sat;
      err_q  <= err_c;
    end
    if (ctl.out_upd) begin
      duty_q <= u_c[FracBits+DutyW-1:FracBits];
      vout_q <= volt_q;
    end else if (ctl.out_off) begin
      duty_q <= DutyOff;
      vout_q <= '0;
    end
  end

endmodule

[rtl/pi_voltage_regulator_pwm.sv]
// Top level of the PI voltage regulator with PWM duty output.
// Depends on pvr_pkg, pvr_if, pvr_cfg, pvr_front, pvr_fifo and pvr_back.
//
// The block sums SAMPLES_PER_UPDATE ADC samples and then runs one PI update in
// Q16.16 with back-calculation anti-windup, returning the duty and the measured
// voltage; a beat with enable low returns duty 255 and voltage 0 and restarts
// the sum. The front end takes one sample beat per cycle while its two-entry
// job queue has room. An update runs the control sequencer through ERR, KI,
// INT, KP and CTRL, with three passes through one shared multiplier, plus any
// wait in CTRL for the result register to drain; a disable beat is popped in
// idle. Write registers over APB only while the block is idle; not enforced.
module pi_voltage_regulator_pwm #(
  parameter int unsigned SAMPLES_PER_UPDATE = pvr_pkg::SampPerUpdDef,
  parameter int unsigned ADC_BITS           = pvr_pkg::AdcBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pvr_pkg::AddrW-1:0] paddr,
  input  logic [pvr_pkg::DataW-1:0] pwdata,
  output logic [pvr_pkg::DataW-1:0] prdata,
  output logic                      pready,
  pvr_in_if.sink                    smp_i,
  pvr_out_if.source                 res_o
);
  import pvr_pkg::*;

  cfg_t cfg;
  job_t push_job, head_job;
  logic push, full, head_valid, pop;

  pvr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pvr_front #(
    .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE),
    .ADC_BITS           (ADC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  pvr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .valid_o     (head_valid),
    .data_o      (head_job),
    .pop_i       (pop)
  );

  pvr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .res_o       (res_o)
  );

endmodule
